FILE: rtl/tfs_pkg.sv
// Shared types, codes and constants of the timed frame sequencer.
`default_nettype none

package tfs_pkg;

	// Default table depth and the depth of the internal queues.
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;

	// Field widths fixed by the item format.
	localparam int REQ_W     = 2;
	localparam int IDX_W     = 4;
	localparam int KIND_W    = 2;
	localparam int FRAME_W   = 10;
	localparam int DUR_W     = 16;
	localparam int ELAPSED_W = 16;
	localparam int TIMER_W   = 17;

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

	// Request codes on req_type.
	localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

	// Entry kinds; every other kind acts as an end entry.
	localparam logic [KIND_W-1:0] KIND_PLAY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOP = 2'd1;

	// Operation handed from the front to the back.
	typedef enum logic [1:0] {
		OP_NOP,
		OP_LOAD,
		OP_TICK,
		OP_RESTART
	} op_t;

	// Sequencer states of the back part.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NEXT,
		ST_TARGET
	} state_t;

	// One table entry as stored.
	typedef struct packed {
		logic [IDX_W-1:0]   tgt;
		logic [DUR_W-1:0]   dur;
		logic [FRAME_W-1:0] frame;
		logic [KIND_W-1:0]  kind;
	} entry_t;

	// Classified command in the queue between front and back.
	typedef struct packed {
		op_t                  op;
		logic [IDX_W-1:0]     idx;
		entry_t               word;
		logic [ELAPSED_W-1:0] elapsed;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               ended;
		logic               err;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/tfs_fifo.sv
// Small synchronous queue with full and empty flags.
`default_nettype none

module tfs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = store_q[rd_ptr_q];

	// Pointer and fill count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tfs_front.sv
// Front part: classifies incoming transactions and queues them for the sequencer.
`default_nettype none

module tfs_front #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [1:0]              req_type,
	input  wire logic [3:0]              entry_index,
	input  wire logic [1:0]              entry_kind,
	input  wire logic [9:0]              entry_frame,
	input  wire logic [15:0]             entry_duration,
	input  wire logic [3:0]              entry_loop_target,
	input  wire logic [15:0]             elapsed,
	output tfs_pkg::cmd_t                cmd,
	output logic                         cmd_empty,
	input  wire logic                    cmd_pop
);

	import tfs_pkg::*;

	cmd_t             cmd_in;
	logic [$bits(cmd_t)-1:0] cmd_raw;

	// Decode the request and turn loads that fall outside the table into no-ops.
	always_comb begin
		cmd_in.idx     = entry_index;
		cmd_in.elapsed = elapsed;
		cmd_in.word    = '{tgt: entry_loop_target, dur: entry_duration,
			frame: entry_frame, kind: entry_kind};
		unique case (req_type)
			REQ_LOAD: begin
				cmd_in.op = (int'(entry_index) < TABLE_DEPTH) ? OP_LOAD : OP_NOP;
			end
			REQ_TICK:    cmd_in.op = OP_TICK;
			REQ_RESTART: cmd_in.op = OP_RESTART;
			default:     cmd_in.op = OP_NOP;
		endcase
	end

	// Command queue toward the back part.
	tfs_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_raw),
		.empty   (cmd_empty)
	);

	assign cmd = cmd_t'(cmd_raw);

endmodule

`default_nettype wire

FILE: rtl/tfs_back.sv
// Back part: command table, frame timer and the sequencing state machine.
`default_nettype none

module tfs_back #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tfs_pkg::cmd_t cmd,
	input  wire logic          cmd_empty,
	output logic               cmd_pop,
	input  wire logic          res_full,
	output logic               res_push,
	output tfs_pkg::res_t      res
);

	import tfs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	// Command table, one write port and one registered read port.
	entry_t mem [TABLE_DEPTH];
	entry_t rd_q;

	state_t           state_q;
	state_t           state_d;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    pos_d;
	logic [AW-1:0]    shown_q;
	logic [AW-1:0]    shown_d;
	logic [TIMER_W-1:0] timer_q;
	logic [TIMER_W-1:0] timer_d;
	logic             done_q;
	logic             done_d;
	entry_t           cur_q;
	entry_t           cur_d;
	entry_t           ent0_q;
	entry_t           ent0_d;

	logic             go;
	logic [TIMER_W:0] sum;
	logic [TIMER_W-1:0] sat;
	logic             reach;
	logic [AW-1:0]    pos_inc;
	logic [AW-1:0]    load_addr;
	logic [AW-1:0]    tgt_addr;
	logic             tgt_ok;
	logic             adv;
	logic             mem_we;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             err;

	// Shared decode for both control blocks.
	assign go        = !cmd_empty && !res_full;
	assign sum       = {1'b0, timer_q} + (TIMER_W + 1)'(cmd.elapsed);
	assign sat       = (sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : sum[TIMER_W-1:0];
	assign reach     = (sat >= TIMER_W'(cur_q.dur));
	assign pos_inc   = (int'(pos_q) == TABLE_DEPTH - 1) ? '0 : pos_q + AW'(1);
	assign load_addr = AW'(cmd.idx);
	assign tgt_addr  = AW'(rd_q.tgt);
	assign tgt_ok    = (int'(rd_q.tgt) < TABLE_DEPTH);
	assign adv       = go && (cmd.op == OP_TICK) && !done_q && reach;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (adv) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (rd_q.kind == KIND_LOOP && tgt_ok) begin
					state_d = ST_TARGET;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TARGET: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Datapath updates, table access and result transactions.
	always_comb begin
		pos_d    = pos_q;
		shown_d  = shown_q;
		timer_d  = timer_q;
		done_d   = done_q;
		cur_d    = cur_q;
		ent0_d   = ent0_q;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = pos_inc;
		res_push = 1'b0;
		cmd_pop  = 1'b0;
		err      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (go) begin
					cmd_pop  = 1'b1;
					res_push = 1'b1;
					case (cmd.op)
						OP_LOAD: begin
							mem_we = 1'b1;
							if (load_addr == shown_q) begin
								cur_d = cmd.word;
							end
							if (load_addr == '0) begin
								ent0_d = cmd.word;
							end
						end
						OP_RESTART: begin
							pos_d   = '0;
							shown_d = '0;
							timer_d = '0;
							done_d  = 1'b0;
							cur_d   = ent0_q;
						end
						OP_TICK: begin
							if (!done_q) begin
								if (reach) begin
									// Duration reached: fetch the next entry.
									timer_d  = '0;
									pos_d    = pos_inc;
									rd_en    = 1'b1;
									res_push = 1'b0;
								end else begin
									timer_d = sat;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_NEXT: begin
				res_push = 1'b1;
				if (rd_q.kind == KIND_PLAY) begin
					shown_d = pos_q;
					cur_d   = rd_q;
				end else if (rd_q.kind == KIND_LOOP) begin
					if (tgt_ok) begin
						// Target in range: jump there and read the target entry to check it.
						pos_d    = tgt_addr;
						rd_addr  = tgt_addr;
						rd_en    = 1'b1;
						res_push = 1'b0;
					end else begin
						err     = 1'b1;
						pos_d   = '0;
						shown_d = '0;
						done_d  = 1'b0;
						cur_d   = ent0_q;
					end
				end else begin
					done_d = 1'b1;
				end
			end
			ST_TARGET: begin
				res_push = 1'b1;
				if (rd_q.kind == KIND_PLAY) begin
					shown_d = pos_q;
					cur_d   = rd_q;
				end else begin
					err     = 1'b1;
					pos_d   = '0;
					shown_d = '0;
					done_d  = 1'b0;
					cur_d   = ent0_q;
				end
			end
			default: begin
			end
		endcase
		res.frame = cur_d.frame;
		res.ended = done_d;
		res.err   = err;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			shown_q <= '0;
			timer_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			shown_q <= shown_d;
			timer_q <= timer_d;
			done_q  <= done_d;
		end
	end

	// Cached copies of the shown entry and of entry zero.
	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		ent0_q <= ent0_d;
	end

	// Table write and registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[load_addr] <= cmd.word;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/timed_frame_sequencer_core.sv
// Top level of the timed frame sequencer: front, back and result queue.
//
// Both sides look like queues. An input transaction is taken when push is
// high and full is low; req_type selects load entry, time tick or restart.
// Every input transaction yields exactly one result transaction, offered
// while empty is low and taken when pop is high.
// Loads, restarts and ticks that do not end the shown frame pass through the
// command queue, the back part and the result queue. A tick that ends the
// frame also waits for the table read of the next entry, and for one more
// read when that entry is a loop whose target must be checked. The single
// read port of the command table causes these waits; all other transactions
// are taken one per cycle while the result queue is not full.
// Reset clears the position, shown entry index, frame timer, ended flag and both
// queues; the command table holds nothing defined until it is loaded.
// When the receiver stalls, results collect in a two-entry queue, then the
// sequencer holds, then the command queue fills and full goes high.
`default_nettype none

module timed_frame_sequencer_core #(
	parameter int TABLE_DEPTH = tfs_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  req_type,
	input  wire logic [3:0]  entry_index,
	input  wire logic [1:0]  entry_kind,
	input  wire logic [9:0]  entry_frame,
	input  wire logic [15:0] entry_duration,
	input  wire logic [3:0]  entry_loop_target,
	input  wire logic [15:0] elapsed,
	output logic             empty,
	input  wire logic        pop,
	output logic [9:0]       frame_now,
	output logic             is_ended,
	output logic             loop_error
);

	import tfs_pkg::*;

	cmd_t cmd;
	logic cmd_empty;
	logic cmd_pop;
	logic res_full;
	logic res_push;
	res_t res_in;
	res_t res_out;
	logic [$bits(res_t)-1:0] res_raw;

	// Classify and queue input transactions.
	tfs_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.req_type          (req_type),
		.entry_index       (entry_index),
		.entry_kind        (entry_kind),
		.entry_frame       (entry_frame),
		.entry_duration    (entry_duration),
		.entry_loop_target (entry_loop_target),
		.elapsed           (elapsed),
		.cmd               (cmd),
		.cmd_empty         (cmd_empty),
		.cmd_pop           (cmd_pop)
	);

	// Carry out commands against the table and timer.
	tfs_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result queue toward the receiver.
	tfs_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_raw),
		.empty   (empty)
	);

	assign res_out    = res_t'(res_raw);
	assign frame_now  = res_out.frame;
	assign is_ended   = res_out.ended;
	assign loop_error = res_out.err;

endmodule

`default_nettype wire
